// File: rtl/led_pkg.sv
// Shared types and constants for the logo erase pixel divide block.
// Used by led_div_cell, led_div_chain and logo_erase_pixel_divide_core.
`timescale 1ns / 1ps
`default_nettype none
package led_pkg;

	localparam int DivW     = 38;
	localparam int NumW     = 39;
	localparam int MaxDp    = 1000;
	localparam int InvShift = 30;
	localparam int ScaleW   = 20;

	typedef struct packed {
		logic signed [NumW-1:0] num;
		logic [4:0]             bd;
		logic                   flag;
	} side_t;

	typedef struct packed {
		logic            vld;
		logic [DivW-1:0] dvd;
		logic [DivW-1:0] rem;
		logic [DivW-1:0] den;
		logic [DivW-1:0] quo;
		side_t           side;
	} lane_t;

endpackage
`default_nettype wire

// File: rtl/led_div_cell.sv
// One restoring division step: produces one quotient bit per cycle while en is high.
// Depends on led_pkg for the lane type.
`timescale 1ns / 1ps
`default_nettype none
module led_div_cell (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             en,
	input  led_pkg::lane_t  lane_in,
	output led_pkg::lane_t  lane_out
);

	logic [led_pkg::DivW:0]   trial;
	logic                     qbit;
	logic                     vld_q;
	led_pkg::lane_t           data_q;
	led_pkg::lane_t           nxt;

	assign trial = {lane_in.rem, lane_in.dvd[led_pkg::DivW-1]} - {1'b0, lane_in.den};
	assign qbit  = ~trial[led_pkg::DivW];

	always_comb begin
		nxt      = lane_in;
		nxt.dvd  = {lane_in.dvd[led_pkg::DivW-2:0], 1'b0};
		nxt.quo  = {lane_in.quo[led_pkg::DivW-2:0], qbit};
		nxt.rem  = qbit ? trial[led_pkg::DivW-1:0]
		                : {lane_in.rem[led_pkg::DivW-2:0], lane_in.dvd[led_pkg::DivW-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= lane_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	always_comb begin
		lane_out     = data_q;
		lane_out.vld = vld_q;
	end

endmodule
`default_nettype wire

// File: rtl/led_div_chain.sv
// A row of division cells, one per quotient bit.
// Depends on led_pkg and led_div_cell.
`timescale 1ns / 1ps
`default_nettype none
module led_div_chain (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             en,
	input  led_pkg::lane_t  lane_in,
	output led_pkg::lane_t  lane_out
);

	led_pkg::lane_t lanes [0:led_pkg::DivW];

	assign lanes[0] = lane_in;

	for (genvar i = 0; i < led_pkg::DivW; i++) begin : g_cell
		led_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.lane_in  (lanes[i]),
			.lane_out (lanes[i+1])
		);
	end

	assign lane_out = lanes[led_pkg::DivW];

endmodule
`default_nettype wire

// File: rtl/logo_erase_pixel_divide_core.sv
// Top level of the logo erase pixel divide block.
// Depends on led_pkg and led_div_chain.
//
// Usage: one pixel beat enters on in_valid/in_ready with pixel_in, logo_color
// and logo_depth; one result beat leaves on out_valid/out_ready with pixel_out
// and divide_fault. The bit_depth register is written through cfg_valid and
// cfg_data; cfg_ready is always high, and writes belong to idle periods.
// Throughput is one pixel per cycle while the receiver takes results. The input
// arithmetic (scale, multiply by the opacity constant, add color) is
// combinational and lands in the first cell's register, then a row of
// 38 cells forms 2^30 / depth one bit per cell, a second row of 38 cells
// divides the numerator by that inverse, and an output register holds the
// rounded and clamped result. Every cell holds one beat in flight.
// When the receiver stalls with a result waiting, the whole pipe holds and
// in_ready drops. Reset clears all valid bits and sets bit_depth to 8.
`timescale 1ns / 1ps
`default_nettype none
module logo_erase_pixel_divide_core (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire  [4:0]         cfg_data,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire  [15:0]        pixel_in,
	input  wire  signed [31:0] logo_color,
	input  wire  [30:0]        logo_depth,
	output logic               out_valid,
	input  wire                out_ready,
	output logic [15:0]        pixel_out,
	output logic               divide_fault
);

	logic [4:0]  bit_depth_q;
	logic        en;
	logic [4:0]  bd_eff;
	logic [4:0]  shift;
	logic [27:0] scaled;
	logic [led_pkg::DivW-1:0] prod;
	logic signed [led_pkg::NumW-1:0] num;

	led_pkg::lane_t in_lane, mid_lane, mid_in, fin_lane;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_depth_q <= 5'd8;
		end else if (cfg_valid) begin
			bit_depth_q <= cfg_data;
		end
	end

	// The whole pipe moves together unless a finished result is held.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_comb begin
		if (bit_depth_q < 5'd8) begin
			bd_eff = 5'd8;
		end else if (bit_depth_q > 5'd16) begin
			bd_eff = 5'd16;
		end else begin
			bd_eff = bit_depth_q;
		end
	end

	assign shift  = 5'(led_pkg::ScaleW) - bd_eff;
	assign scaled = {12'd0, pixel_in} << shift;
	assign prod   = led_pkg::DivW'(scaled) * led_pkg::DivW'(led_pkg::MaxDp);
	assign num    = $signed({1'b0, prod}) + led_pkg::NumW'(logo_color);

	// First row: 2^30 divided by the depth coefficient.
	always_comb begin
		in_lane           = '0;
		in_lane.vld       = in_valid;
		in_lane.dvd       = led_pkg::DivW'(1) << led_pkg::InvShift;
		in_lane.den       = led_pkg::DivW'(logo_depth);
		in_lane.side.num  = num;
		in_lane.side.bd   = bd_eff;
		in_lane.side.flag = (logo_depth == 31'd0);
	end

	led_div_chain u_inv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.lane_in  (in_lane),
		.lane_out (mid_lane)
	);

	// Second row: the numerator over the inverse. A negative numerator
	// clamps to zero, so it enters as zero.
	always_comb begin
		mid_in           = '0;
		mid_in.vld       = mid_lane.vld;
		mid_in.side      = mid_lane.side;
		mid_in.side.flag = mid_lane.side.flag || (mid_lane.quo == '0);
		mid_in.den       = mid_lane.quo;
		mid_in.dvd       = mid_lane.side.num[led_pkg::NumW-1] ? '0
		                   : mid_lane.side.num[led_pkg::DivW-1:0];
	end

	led_div_chain u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.lane_in  (mid_in),
		.lane_out (fin_lane)
	);

	logic [4:0]               down;
	logic [led_pkg::DivW-1:0] q_sh;
	logic [led_pkg::DivW-1:0] q_rnd;
	logic [16:0]              pmax;
	logic [15:0]              res;

	always_comb begin
		down  = 5'd16 - fin_lane.side.bd;
		q_sh  = fin_lane.quo >> down;
		q_rnd = (q_sh + led_pkg::DivW'(1)) >> 2;
		pmax  = (17'd1 << fin_lane.side.bd) - 17'd1;
		if (fin_lane.side.flag || q_rnd > led_pkg::DivW'(pmax)) begin
			res = pmax[15:0];
		end else begin
			res = q_rnd[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= fin_lane.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pixel_out    <= res;
			divide_fault <= fin_lane.side.flag;
		end
	end

endmodule
`default_nettype wire
